// File: src/gnbe_pkg.sv
package gnbe_pkg;

    // Store geometry
    localparam int NODE_COUNT    = 1024;
    localparam int PATTERN_WIDTH = 64;
    localparam int NODE_W        = 10;
    localparam int VALUE_W       = 64;

    // Word layout on the streams
    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 1;

    typedef logic [NODE_W-1:0]        node_t;
    typedef logic [PATTERN_WIDTH-1:0] vec_t;
    typedef logic [1:0]               mode_t;
    typedef logic [3:0]               kind_t;

    // Item modes
    localparam mode_t MODE_LOAD = 2'd0;
    localparam mode_t MODE_EVAL = 2'd1;
    localparam mode_t MODE_READ = 2'd2;

    // Gate kinds
    localparam kind_t GATE_AND    = 4'd0;
    localparam kind_t GATE_NOT    = 4'd1;
    localparam kind_t GATE_NAND   = 4'd2;
    localparam kind_t GATE_ANDNOT = 4'd3;
    localparam kind_t GATE_OR     = 4'd4;
    localparam kind_t GATE_NOR    = 4'd5;
    localparam kind_t GATE_ORNOT  = 4'd6;
    localparam kind_t GATE_XOR    = 4'd7;
    localparam kind_t GATE_XNOR   = 4'd8;

    // Outcome of one gate evaluation
    typedef struct packed {
        vec_t value;
        logic bad;
    } gate_res_t;

endpackage

// File: src/gate_netlist_bit_parallel_eval.sv
// Channel | Dir | Signals                     | Word contents
// --------+-----+-----------------------------+---------------------------------------
// s       | in  | s_tvalid s_tready s_tdata   | node, gate_kind, first_source,
//         |     | s_tuser                     | second_source, load_value; tuser = mode
// m       | out | m_tvalid m_tready m_tdata   | node_value; tuser = bad_gate
//
// One word per cycle while the output is not stalled; each word passes the gate stage and then the output register.
// The node store is a 1024 x 64 memory with two registered read ports and one
// write port; a write from the gate stage is forwarded to a read issued at the
// same edge. Reset (rst_n low, asynchronous) empties the pipeline only; node
// contents are undefined until written. A stalled output holds the gate stage,
// which in turn holds s_tready low.
module gate_netlist_bit_parallel_eval (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [9:0] node, [13:10] gate_kind, [23:14] first_source,
    // [33:24] second_source, [97:34] load_value, [103:98] zero
    input  logic [gnbe_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] mode
    input  logic [gnbe_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [63:0] node_value
    output logic [gnbe_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] bad_gate
    output logic [gnbe_pkg::M_TUSER_W-1:0]    m_tuser
);
    import gnbe_pkg::*;

    // Unpack the input word
    node_t in_node;
    kind_t in_kind;
    node_t in_src_a;
    node_t in_src_b;
    vec_t  in_load;
    mode_t in_mode;

    assign in_node  = s_tdata[9:0];
    assign in_kind  = s_tdata[13:10];
    assign in_src_a = s_tdata[23:14];
    assign in_src_b = s_tdata[33:24];
    assign in_load  = s_tdata[34 +: PATTERN_WIDTH];
    assign in_mode  = s_tuser;

    // Pipeline control
    logic  s1_valid_reg;
    logic  out_valid_reg;
    logic  s1_adv;
    logic  accept;

    assign s1_adv   = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // Gate stage item registers
    mode_t s1_mode_reg;
    node_t s1_node_reg;
    kind_t s1_kind_reg;
    vec_t  s1_load_reg;

    // Node store and its read data
    vec_t  mem [NODE_COUNT];
    vec_t  rd_a_reg;
    vec_t  rd_b_reg;
    node_t addr_a;

    // Port A serves the first source, or the node itself for a read
    assign addr_a = (in_mode == MODE_READ) ? in_node : in_src_a;

    // Gate stage compute
    gate_res_t gate_res;
    vec_t      s1_value;
    logic      s1_bad;
    logic      s1_we;
    logic      wr_en;

    gnbe_gate u_gate (
        .kind (s1_kind_reg),
        .a    (rd_a_reg),
        .b    (rd_b_reg),
        .res  (gate_res)
    );

    always_comb
    begin
        s1_value = '0;
        s1_bad   = 1'b0;
        s1_we    = 1'b0;
        case (s1_mode_reg)
            MODE_LOAD:
            begin
                s1_value = s1_load_reg;
                s1_we    = 1'b1;
            end
            MODE_EVAL:
            begin
                s1_value = gate_res.value;
                s1_bad   = gate_res.bad;
                s1_we    = !gate_res.bad;
            end
            MODE_READ:
            begin
                s1_value = rd_a_reg;
            end
            default:
            begin
                s1_value = '0;
            end
        endcase
    end

    assign wr_en = s1_valid_reg && s1_adv && s1_we;

    // Write back the gate stage result
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_node_reg] <= s1_value;
        end
    end

    // Read both sources, forwarding a write that lands at the same edge
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (wr_en && (s1_node_reg == addr_a))
            begin
                rd_a_reg <= s1_value;
            end
            else
            begin
                rd_a_reg <= mem[addr_a];
            end
            if (wr_en && (s1_node_reg == in_src_b))
            begin
                rd_b_reg <= s1_value;
            end
            else
            begin
                rd_b_reg <= mem[in_src_b];
            end
        end
    end

    // Capture the item into the gate stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= in_mode;
            s1_node_reg <= in_node;
            s1_kind_reg <= in_kind;
            s1_load_reg <= in_load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // Output register
    vec_t out_data_reg;
    logic out_bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_data_reg <= s1_value;
            out_bad_reg  <= s1_bad;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = M_TDATA_W'(out_data_reg);
    assign m_tuser[0] = out_bad_reg;

`ifndef SYNTHESIS
    // An accepted word occupies the gate stage on the next cycle
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted word did not reach the gate stage");

    // A held gate stage keeps its item
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_node_reg)
                                       && $stable(s1_mode_reg)))
        else $error("gate stage item changed while stalled");

    // A bad gate never writes the store
    a_no_bad_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !s1_bad)
        else $error("store written for an invalid gate kind");

    // Only evaluate words can flag a bad gate
    a_bad_eval_only: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_adv && (s1_mode_reg != MODE_EVAL)) |=> !m_tuser[0])
        else $error("bad_gate set for a non-evaluate word");
`endif

endmodule

// File: src/gnbe_gate.sv
module gnbe_gate (
    input  gnbe_pkg::kind_t     kind,
    input  gnbe_pkg::vec_t      a,
    input  gnbe_pkg::vec_t      b,
    output gnbe_pkg::gate_res_t res
);
    import gnbe_pkg::*;

    // Combine the two operand vectors bitwise
    always_comb
    begin
        res.bad   = 1'b0;
        res.value = '0;
        case (kind)
            GATE_AND:    res.value = a & b;
            GATE_NOT:    res.value = ~a;
            GATE_NAND:   res.value = ~(a & b);
            GATE_ANDNOT: res.value = a & ~b;
            GATE_OR:     res.value = a | b;
            GATE_NOR:    res.value = ~(a | b);
            GATE_ORNOT:  res.value = a | ~b;
            GATE_XOR:    res.value = a ^ b;
            GATE_XNOR:   res.value = ~(a ^ b);
            default:
            begin
                res.value = '0;
                res.bad   = 1'b1;
            end
        endcase
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import gnbe_pkg::*;

    // Codes the package does not name
    localparam mode_t MODE_SPARE  = 2'd3;
    localparam kind_t GATE_BAD_LO = 4'd9;
    localparam kind_t GATE_BAD_HI = 4'd15;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 250;
    localparam int ITEM_TARGET = 1700;

    // Mirror of the node store and the results still owed by the block
    class node_vector_board;
        vec_t      node_vecs [NODE_COUNT];
        gate_res_t owed_results [$];
        int        failures;

        function new();
            failures = 0;
        endfunction

        // Predict the result of one accepted input word
        function void note_word(mode_t mode, node_t node, kind_t kind,
                                node_t src_a, node_t src_b, vec_t load);
            gate_res_t want;
            vec_t      a;
            vec_t      b;
            want.value = '0;
            want.bad   = 1'b0;
            a = node_vecs[src_a];
            b = node_vecs[src_b];
            case (mode)
                MODE_LOAD:
                begin
                    want.value = load;
                    node_vecs[node] = load;
                end
                MODE_EVAL:
                begin
                    case (kind)
                        GATE_AND:    want.value = a & b;
                        GATE_NOT:    want.value = ~a;
                        GATE_NAND:   want.value = ~(a & b);
                        GATE_ANDNOT: want.value = a & ~b;
                        GATE_OR:     want.value = a | b;
                        GATE_NOR:    want.value = ~(a | b);
                        GATE_ORNOT:  want.value = a | ~b;
                        GATE_XOR:    want.value = a ^ b;
                        GATE_XNOR:   want.value = ~(a ^ b);
                        default:     want.bad = 1'b1;
                    endcase
                    if (!want.bad)
                        node_vecs[node] = want.value;
                end
                MODE_READ:
                    want.value = node_vecs[node];
                default:
                    want.value = '0;
            endcase
            owed_results.push_back(want);
        endfunction

        // Compare one accepted output word with the oldest prediction
        function void check_word(vec_t value, logic bad);
            gate_res_t want;
            if (owed_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with nothing owed: value=%h bad=%b",
                             $realtime, value, bad);
                return;
            end
            want = owed_results.pop_front();
            if (value !== want.value || bad !== want.bad)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch: expected value=%h bad=%b, got value=%h bad=%b",
                             $realtime, want.value, want.bad, value, bad);
            end
        endfunction

        // Count predictions that never got a result
        function void settle();
            if (owed_results.size() != 0)
            begin
                failures += owed_results.size();
                $display("%0d results never arrived", owed_results.size());
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    node_vector_board board = new();

    bit    written [NODE_COUNT];
    node_t written_list [$];
    int    sent;
    bit    idling;
    bit    long_hold;
    bit    hold_done;
    bit    pause_done;

    gate_netlist_bit_parallel_eval uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    // Predict and check on accepted words
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.note_word(mode_t'(s_tuser), node_t'(s_tdata[9:0]),
                            kind_t'(s_tdata[13:10]), node_t'(s_tdata[23:14]),
                            node_t'(s_tdata[33:24]), vec_t'(s_tdata[97:34]));
        if (rst_n && m_tvalid && m_tready)
            board.check_word(m_tdata, m_tuser[0]);
    end

    // End the run when nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** gate_netlist_bit_parallel_eval: FAILED **");
        $finish;
    end

    // Drive m_tready in bursts, with one long hold on request
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (idling && $urandom_range(0, 3) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            else
            begin
                m_tready = 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
        end
    end

    function automatic void mark_written(node_t n);
        if (!written[n])
        begin
            written[n] = 1'b1;
            written_list.push_back(n);
        end
    endfunction

    // Pick a node that holds a value, often a recent one to build chains
    function automatic node_t pick_written();
        int sz;
        int span;
        sz = written_list.size();
        if ($urandom_range(0, 1) == 0)
        begin
            span = (sz > 8) ? 7 : sz - 1;
            return written_list[sz - 1 - $urandom_range(0, span)];
        end
        return written_list[$urandom_range(0, sz - 1)];
    endfunction

    function automatic vec_t rand_vec();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one word at the falling edge and hold it until accepted
    task automatic send_word(mode_t mode, node_t node, kind_t kind,
                             node_t src_a, node_t src_b, vec_t load);
        s_tdata  = {6'b0, load, src_b, src_a, kind, node};
        s_tuser  = mode;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        sent++;
        if (mode == MODE_LOAD || (mode == MODE_EVAL && kind <= GATE_XNOR))
            mark_written(node);
        if (idling && $urandom_range(0, 7) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (board.owed_results.size() != 0)
            @(negedge clk);
    endtask

    // Load inputs, evaluate a chain of gates, read some nodes back
    task automatic run_netlist();
        int    n_in;
        int    n_gate;
        int    n_read;
        kind_t kind;
        n_in   = $urandom_range(1, 6);
        n_gate = $urandom_range(3, 15);
        n_read = $urandom_range(1, 4);
        repeat (n_in)
            send_word(MODE_LOAD, node_t'($urandom_range(0, NODE_COUNT - 1)),
                      kind_t'($urandom), node_t'($urandom), node_t'($urandom),
                      rand_vec());
        repeat (n_gate)
        begin
            if ($urandom_range(0, 19) == 0)
                kind = kind_t'($urandom_range(GATE_BAD_LO, GATE_BAD_HI));
            else
                kind = kind_t'($urandom_range(GATE_AND, GATE_XNOR));
            send_word(MODE_EVAL, node_t'($urandom_range(0, NODE_COUNT - 1)), kind,
                      pick_written(), pick_written(), vec_t'({$urandom, $urandom}));
        end
        repeat (n_read)
            send_word(MODE_READ, pick_written(), kind_t'($urandom), pick_written(),
                      pick_written(), vec_t'({$urandom, $urandom}));
    endtask

    // Any mode and any kind, with sources kept on written nodes
    task automatic send_noise();
        mode_t mode;
        node_t node;
        mode = mode_t'($urandom_range(MODE_LOAD, MODE_SPARE));
        if (mode == MODE_READ)
            node = pick_written();
        else
            node = node_t'($urandom_range(0, NODE_COUNT - 1));
        send_word(mode, node, kind_t'($urandom_range(GATE_AND, GATE_BAD_HI)),
                  pick_written(), pick_written(), rand_vec());
    endtask

    initial
    begin
        node_t tgt;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = MODE_LOAD;
        sent       = 0;
        idling     = 1'b1;
        long_hold  = 1'b0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: field extremes, every gate kind, bad kinds, spare mode
        send_word(MODE_LOAD, 10'h000, GATE_AND, 10'h000, 10'h000, '1);
        send_word(MODE_LOAD, 10'h3FF, GATE_BAD_HI, 10'h3FF, 10'h3FF, '0);
        send_word(MODE_LOAD, 10'h2AA, GATE_AND, 10'h000, 10'h000,
                  64'hAAAA_AAAA_AAAA_AAAA);
        send_word(MODE_LOAD, 10'h155, GATE_AND, 10'h000, 10'h000,
                  64'h5555_5555_5555_5555);
        send_word(MODE_READ, 10'h000, GATE_AND, 10'h000, 10'h000, '0);
        send_word(MODE_READ, 10'h3FF, GATE_AND, 10'h000, 10'h000, '0);
        for (int k = GATE_AND; k <= GATE_XNOR; k++)
        begin
            tgt = node_t'(10'h100 + k);
            send_word(MODE_EVAL, tgt, kind_t'(k), 10'h2AA, 10'h155, '0);
        end
        send_word(MODE_EVAL, 10'h120, GATE_NOT, 10'h000, 10'h3FF, '0);
        send_word(MODE_EVAL, 10'h3F0, GATE_BAD_LO, 10'h2AA, 10'h155, '1);
        send_word(MODE_EVAL, 10'h3F1, GATE_BAD_HI, 10'h000, 10'h3FF, '1);
        send_word(MODE_SPARE, 10'h3F2, GATE_XOR, 10'h000, 10'h3FF, '1);
        // Overwrite a source in place, then read it back at once
        send_word(MODE_EVAL, 10'h2AA, GATE_XOR, 10'h2AA, 10'h000, '0);
        send_word(MODE_EVAL, 10'h155, GATE_AND, 10'h2AA, 10'h155, '0);
        send_word(MODE_READ, 10'h155, GATE_AND, 10'h000, 10'h000, '0);
        send_word(MODE_READ, 10'h2AA, GATE_AND, 10'h000, 10'h000, '0);
        send_word(MODE_EVAL, 10'h3FF, GATE_NOR, 10'h3FF, 10'h000, '0);
        send_word(MODE_READ, 10'h3FF, GATE_AND, 10'h000, 10'h000, '0);

        // Random: mostly netlist runs, some noise
        while (sent < ITEM_TARGET)
        begin
            idling = !((sent >= 300 && sent < 400) || sent >= 1450);
            if (!hold_done && sent >= 700)
            begin
                long_hold = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && sent >= 1100)
            begin
                wait_drained();
                pause_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 7)
                run_netlist();
            else
                repeat (3) send_noise();
        end

        // Let the pipeline empty, then watch for stray results
        wait_drained();
        repeat (10) @(negedge clk);
        board.settle();
        if (board.failures == 0)
            $display("** gate_netlist_bit_parallel_eval: PASSED **");
        else
            $display("** gate_netlist_bit_parallel_eval: FAILED **");
        $finish;
    end

endmodule
